// File: hw/rtl/gthue_pkg.sv
// Package for the gray-to-color hue transfer block: widths, fixed-point constants and
// the shared types between the front stage, the divider and the back end.
// No dependencies.
`default_nettype none
package gthue_pkg;

    localparam int COMP_W    = 8;
    localparam int DIV_DW    = 8;
    localparam int DIV_QW    = 17;
    localparam int DIV_NW    = DIV_QW + DIV_DW;
    localparam int DIV_LANES = 3;

    localparam int LANE_CHROMA = 0;
    localparam int LANE_HUE    = 1;
    localparam int LANE_LIGHT  = 2;

    localparam int Q16_W = 17;
    localparam int HUE_W = 15;
    localparam int HUE_FRAC_W = 13;
    localparam int VAL_W = 18;

    localparam logic [HUE_W-1:0] HUE_ONE   = 15'd4096;
    localparam logic [HUE_W-1:0] HUE_TWO   = 15'd8192;
    localparam logic [HUE_W-1:0] HUE_THREE = 15'd12288;
    localparam logic [HUE_W-1:0] HUE_FOUR  = 15'd16384;
    localparam logic [HUE_W-1:0] HUE_FIVE  = 15'd20480;
    localparam logic [HUE_W-1:0] HUE_SIX   = 15'd24576;
    localparam logic [HUE_FRAC_W-1:0] FRAC_ONE = 13'd4096;
    localparam logic [Q16_W-1:0] L_SAT = 17'h1FFFF;
    localparam logic [VAL_W-1:0] VAL_FULL = 18'd131072;

    localparam logic CFG_MAX_VALUE = 1'b0;
    localparam logic CFG_MAX_GRAY  = 1'b1;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        sector_t sector;
        logic    neg;
        logic    zero_d;
        logic    l_sat;
    } gthue_info_t;

    localparam int INFO_W = $bits(gthue_info_t);

endpackage
`default_nettype wire

// File: hw/rtl/gthue_front.sv
// Input stage: saturates the reference color, finds max, min, chroma span and hue
// sector, and forms the dividends and divisors of the three divider lanes. Uses gthue_pkg.
`default_nettype none
module gthue_front (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic [gthue_pkg::COMP_W-1:0]                 max_value,
    input  wire logic [gthue_pkg::COMP_W-1:0]                 max_gray,
    input  wire logic                                         in_valid,
    output logic                                              in_ready,
    input  wire logic [gthue_pkg::COMP_W-1:0]                 ref_red,
    input  wire logic [gthue_pkg::COMP_W-1:0]                 ref_green,
    input  wire logic [gthue_pkg::COMP_W-1:0]                 ref_blue,
    input  wire logic [gthue_pkg::COMP_W-1:0]                 gray_level,
    output logic                                              out_valid,
    input  wire logic                                         out_ready,
    output logic [gthue_pkg::DIV_LANES-1:0][gthue_pkg::DIV_NW-1:0] out_num,
    output logic [gthue_pkg::DIV_LANES-1:0][gthue_pkg::DIV_DW-1:0] out_den,
    output gthue_pkg::gthue_info_t                            out_info
);
    import gthue_pkg::*;

    logic [COMP_W-1:0] mv, r, g, b, hi, lo, d, pa, pb, ad;
    logic              lsat;
    gthue_info_t       info_next;
    logic [DIV_LANES-1:0][DIV_NW-1:0] num_next;
    logic [DIV_LANES-1:0][DIV_DW-1:0] den_next;

    logic                              valid_reg;
    logic [DIV_LANES-1:0][DIV_NW-1:0] num_reg;
    logic [DIV_LANES-1:0][DIV_DW-1:0] den_reg;
    gthue_info_t                       info_reg;

    always_comb begin
        mv = (max_value == '0) ? 8'd1 : max_value;
        r  = (ref_red   > mv) ? mv : ref_red;
        g  = (ref_green > mv) ? mv : ref_green;
        b  = (ref_blue  > mv) ? mv : ref_blue;
        hi = (r > g) ? r : g;
        if (b > hi) begin
            hi = b;
        end
        lo = (r < g) ? r : g;
        if (b < lo) begin
            lo = b;
        end
        d = hi - lo;
        if (hi == r) begin
            info_next.sector = SEC_RED;
            pa = g;
            pb = b;
        end else if (hi == g) begin
            info_next.sector = SEC_GREEN;
            pa = b;
            pb = r;
        end else begin
            info_next.sector = SEC_BLUE;
            pa = r;
            pb = g;
        end
        info_next.neg    = (pa < pb);
        ad               = info_next.neg ? (pb - pa) : (pa - pb);
        info_next.zero_d = (d == '0);
        // The lightness only overflows 17 bits once gray reaches twice the full scale.
        lsat             = ({1'b0, gray_level[COMP_W-1:1]} >= max_gray);
        info_next.l_sat  = lsat;

        num_next[LANE_CHROMA] = {1'b0, d, 16'h0000};
        den_next[LANE_CHROMA] = mv;
        num_next[LANE_HUE]    = {5'b0, ad, 12'h000};
        den_next[LANE_HUE]    = (d == '0) ? 8'd1 : d;
        if ((max_gray == '0) || lsat) begin
            num_next[LANE_LIGHT] = '0;
            den_next[LANE_LIGHT] = 8'd1;
        end else begin
            num_next[LANE_LIGHT] = {1'b0, gray_level, 16'h0000}
                                 + {17'b0, max_gray - 8'd1};
            den_next[LANE_LIGHT] = max_gray;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            info_reg <= info_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_info  = info_reg;

endmodule
`default_nettype wire

// File: hw/rtl/gthue_div.sv
// Pipelined restoring divider, a load stage then one quotient bit per stage, several lanes in lockstep
// with a side payload. Uses gthue_pkg for default widths.
`default_nettype none
module gthue_div #(
    parameter int LANES = gthue_pkg::DIV_LANES,
    parameter int QW    = gthue_pkg::DIV_QW,
    parameter int DW    = gthue_pkg::DIV_DW,
    parameter int PW    = gthue_pkg::INFO_W
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [LANES-1:0][QW+DW-1:0]   in_num,
    input  wire logic [LANES-1:0][DW-1:0]      in_den,
    input  wire logic [PW-1:0]                 in_payload,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [LANES-1:0][QW-1:0]           out_quot,
    output logic [PW-1:0]                      out_payload
);
    import gthue_pkg::*;

    localparam int STAGES = QW + 1;

    logic                        valid_reg [STAGES];
    logic [LANES-1:0][DW-1:0]    rem_reg   [STAGES];
    logic [LANES-1:0][QW-1:0]    lowq_reg  [STAGES];
    logic [LANES-1:0][DW-1:0]    den_reg   [STAGES];
    logic [PW-1:0]               pay_reg   [STAGES];
    logic [LANES-1:0][DW-1:0]    rem_next  [STAGES];
    logic [LANES-1:0][QW-1:0]    lowq_next [STAGES];
    logic [LANES-1:0][DW:0]      trial     [STAGES];
    logic [LANES-1:0]            ge        [STAGES];
    logic                        ready     [STAGES+1];

    always_comb begin
        ready[STAGES] = out_ready;
        for (int s = STAGES - 1; s >= 0; s--) begin
            ready[s] = !valid_reg[s] || ready[s+1];
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            rem_next[0][l]  = in_num[l][QW+DW-1:QW];
            lowq_next[0][l] = in_num[l][QW-1:0];
            trial[0][l]     = '0;
            ge[0][l]        = 1'b0;
        end
        for (int s = 1; s < STAGES; s++) begin
            for (int l = 0; l < LANES; l++) begin
                trial[s][l] = {rem_reg[s-1][l], lowq_reg[s-1][l][QW-1]};
                ge[s][l]    = (trial[s][l] >= {1'b0, den_reg[s-1][l]});
                if (ge[s][l]) begin
                    trial[s][l] = trial[s][l] - {1'b0, den_reg[s-1][l]};
                end
                rem_next[s][l]  = trial[s][l][DW-1:0];
                lowq_next[s][l] = {lowq_reg[s-1][l][QW-2:0], ge[s][l]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < STAGES; s++) begin
                valid_reg[s] <= 1'b0;
            end
        end else begin
            if (ready[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int s = 1; s < STAGES; s++) begin
                if (ready[s]) begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[0] && in_valid) begin
            rem_reg[0]  <= rem_next[0];
            lowq_reg[0] <= lowq_next[0];
            den_reg[0]  <= in_den;
            pay_reg[0]  <= in_payload;
        end
        for (int s = 1; s < STAGES; s++) begin
            if (ready[s] && valid_reg[s-1]) begin
                rem_reg[s]  <= rem_next[s];
                lowq_reg[s] <= lowq_next[s];
                den_reg[s]  <= den_reg[s-1];
                pay_reg[s]  <= pay_reg[s-1];
            end
        end
    end

    assign in_ready    = ready[0];
    assign out_valid   = valid_reg[STAGES-1];
    assign out_quot    = lowq_reg[STAGES-1];
    assign out_payload = pay_reg[STAGES-1];

endmodule
`default_nettype wire

// File: hw/rtl/gthue_back.sv
// Back end: hue assembly, secondary component, channel offset and clamp, and output
// scaling, in five register stages. Uses gthue_pkg.
`default_nettype none
module gthue_back (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic [gthue_pkg::COMP_W-1:0]                  max_gray,
    input  wire logic                                          in_valid,
    output logic                                               in_ready,
    input  wire logic [gthue_pkg::DIV_LANES-1:0][gthue_pkg::DIV_QW-1:0] in_quot,
    input  wire gthue_pkg::gthue_info_t                        in_info,
    output logic                                               out_valid,
    input  wire logic                                          out_ready,
    output logic [gthue_pkg::COMP_W-1:0]                       out_red,
    output logic [gthue_pkg::COMP_W-1:0]                       out_green,
    output logic [gthue_pkg::COMP_W-1:0]                       out_blue
);
    import gthue_pkg::*;

    localparam int STAGES = 5;

    function automatic logic [VAL_W-1:0] chan_value(
        input logic [Q16_W-1:0] ch,
        input logic [Q16_W-1:0] l,
        input logic [Q16_W-1:0] c
    );
        logic [Q16_W+1:0] s;
        logic [Q16_W+1:0] cx;
        logic [Q16_W+1:0] df;
        logic [VAL_W-1:0] v;
        s  = {1'b0, ch, 1'b0} + {1'b0, l, 1'b0};
        cx = {2'b0, c};
        df = s - cx;
        if (s < cx) begin
            v = '0;
        end else if (df > {1'b0, VAL_FULL}) begin
            v = VAL_FULL;
        end else begin
            v = df[VAL_W-1:0];
        end
        return v;
    endfunction

    logic valid_reg [STAGES];
    logic ready     [STAGES+1];

    logic [HUE_W-1:0]      h_b_reg, h_c_reg, h_d_reg;
    logic [Q16_W-1:0]      c_b_reg, c_c_reg, c_d_reg;
    logic [Q16_W-1:0]      l_b_reg, l_c_reg, l_d_reg;
    logic [HUE_FRAC_W-1:0] w_c_reg;
    logic [Q16_W+HUE_FRAC_W-1:0] p_d_reg;
    logic [VAL_W-1:0]      v_e_reg [3];
    logic [COMP_W-1:0]     o_reg   [3];

    logic [HUE_W-1:0]      h_b_next, q_h;
    logic [Q16_W-1:0]      l_b_next;
    logic [HUE_FRAC_W-1:0] hm, t, w_c_next;
    logic [Q16_W+HUE_FRAC_W-1:0] p_d_next;
    logic [Q16_W-1:0]      x, cr, cg, cb;
    logic [VAL_W-1:0]      v_e_next [3];
    logic [COMP_W+VAL_W-1:0] prod [3];

    always_comb begin
        ready[STAGES] = out_ready;
        for (int s = STAGES - 1; s >= 0; s--) begin
            ready[s] = !valid_reg[s] || ready[s+1];
        end
    end

    always_comb begin
        q_h = {2'b0, in_quot[LANE_HUE][HUE_FRAC_W-1:0]};
        case (in_info.sector)
            SEC_RED: begin
                if (!in_info.neg) begin
                    h_b_next = q_h;
                end else if (q_h == '0) begin
                    h_b_next = '0;
                end else begin
                    h_b_next = HUE_SIX - q_h;
                end
            end
            SEC_GREEN: h_b_next = in_info.neg ? (HUE_TWO - q_h) : (HUE_TWO + q_h);
            SEC_BLUE:  h_b_next = in_info.neg ? (HUE_FOUR - q_h) : (HUE_FOUR + q_h);
            default:   h_b_next = '0;
        endcase
        if (in_info.zero_d) begin
            h_b_next = '0;
        end
        l_b_next = in_info.l_sat ? L_SAT : in_quot[LANE_LIGHT];

        hm = h_b_reg[HUE_FRAC_W-1:0];
        t  = (hm >= FRAC_ONE) ? (hm - FRAC_ONE) : (FRAC_ONE - hm);
        w_c_next = FRAC_ONE - t;

        p_d_next = {{HUE_FRAC_W{1'b0}}, c_c_reg} * {{Q16_W{1'b0}}, w_c_reg};

        x = p_d_reg[Q16_W+11:12];
        if (h_d_reg <= HUE_ONE) begin
            cr = c_d_reg; cg = x;       cb = '0;
        end else if (h_d_reg <= HUE_TWO) begin
            cr = x;       cg = c_d_reg; cb = '0;
        end else if (h_d_reg <= HUE_THREE) begin
            cr = '0;      cg = c_d_reg; cb = x;
        end else if (h_d_reg <= HUE_FOUR) begin
            cr = '0;      cg = x;       cb = c_d_reg;
        end else if (h_d_reg <= HUE_FIVE) begin
            cr = x;       cg = '0;      cb = c_d_reg;
        end else begin
            cr = c_d_reg; cg = '0;      cb = x;
        end
        v_e_next[0] = chan_value(cr, l_d_reg, c_d_reg);
        v_e_next[1] = chan_value(cg, l_d_reg, c_d_reg);
        v_e_next[2] = chan_value(cb, l_d_reg, c_d_reg);

        for (int k = 0; k < 3; k++) begin
            prod[k] = {{VAL_W{1'b0}}, max_gray} * {{COMP_W{1'b0}}, v_e_reg[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < STAGES; s++) begin
                valid_reg[s] <= 1'b0;
            end
        end else begin
            if (ready[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int s = 1; s < STAGES; s++) begin
                if (ready[s]) begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[0] && in_valid) begin
            h_b_reg <= h_b_next;
            c_b_reg <= in_quot[LANE_CHROMA];
            l_b_reg <= l_b_next;
        end
        if (ready[1] && valid_reg[0]) begin
            h_c_reg <= h_b_reg;
            c_c_reg <= c_b_reg;
            l_c_reg <= l_b_reg;
            w_c_reg <= w_c_next;
        end
        if (ready[2] && valid_reg[1]) begin
            h_d_reg <= h_c_reg;
            c_d_reg <= c_c_reg;
            l_d_reg <= l_c_reg;
            p_d_reg <= p_d_next;
        end
        if (ready[3] && valid_reg[2]) begin
            for (int k = 0; k < 3; k++) begin
                v_e_reg[k] <= v_e_next[k];
            end
        end
        if (ready[4] && valid_reg[3]) begin
            for (int k = 0; k < 3; k++) begin
                o_reg[k] <= prod[k][COMP_W+16:17];
            end
        end
    end

    assign in_ready  = ready[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_red   = o_reg[0];
    assign out_green = o_reg[1];
    assign out_blue  = o_reg[2];

endmodule
`default_nettype wire

// File: hw/rtl/gray_to_color_hue_transfer.sv
// Top level of the gray-to-color hue transfer block: configuration registers, front
// stage, pipelined divider and back end. Uses gthue_pkg, gthue_front, gthue_div, gthue_back.
//
//   Channel | Direction | Handshake         | Word
//   s_      | in        | s_tvalid/s_tready | ref_red, ref_green, ref_blue, gray_level
//   m_      | out       | m_tvalid/m_tready | out_red, out_green, out_blue
//   cfg_    | in        | cfg_wr_en         | cfg_index, cfg_wdata
//
// One word is accepted per cycle while the output is not stalled; the pipeline has 1 front stage, 18 divider
// stages (a load stage, then one quotient bit per stage) and 5 back-end stages.
// Reset is synchronous and active low; both registers return to 255.
// A stall on the output fills empty stages first and only then holds the input.
`default_nettype none
module gray_to_color_hue_transfer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // ref_red, ref_green, ref_blue, gray_level
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // out_red, out_green, out_blue
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata
);
    import gthue_pkg::*;

    logic [COMP_W-1:0] max_value_reg, max_gray_reg;

    logic                              f_valid, f_ready;
    logic [DIV_LANES-1:0][DIV_NW-1:0] f_num;
    logic [DIV_LANES-1:0][DIV_DW-1:0] f_den;
    gthue_info_t                       f_info;

    logic                              d_valid, d_ready;
    logic [DIV_LANES-1:0][DIV_QW-1:0] d_quot;
    logic [INFO_W-1:0]                 d_payload;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_value_reg <= 8'd255;
            max_gray_reg  <= 8'd255;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_VALUE: max_value_reg <= cfg_wdata;
                CFG_MAX_GRAY:  max_gray_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    gthue_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .max_value  (max_value_reg),
        .max_gray   (max_gray_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .ref_red    (s_tdata[7:0]),
        .ref_green  (s_tdata[15:8]),
        .ref_blue   (s_tdata[23:16]),
        .gray_level (s_tdata[31:24]),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_num    (f_num),
        .out_den    (f_den),
        .out_info   (f_info)
    );

    gthue_div #(
        .LANES (DIV_LANES),
        .QW    (DIV_QW),
        .DW    (DIV_DW),
        .PW    (INFO_W)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (f_valid),
        .in_ready    (f_ready),
        .in_num      (f_num),
        .in_den      (f_den),
        .in_payload  (f_info),
        .out_valid   (d_valid),
        .out_ready   (d_ready),
        .out_quot    (d_quot),
        .out_payload (d_payload)
    );

    gthue_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .max_gray  (max_gray_reg),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_quot   (d_quot),
        .in_info   (gthue_info_t'(d_payload)),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_red   (m_tdata[7:0]),
        .out_green (m_tdata[15:8]),
        .out_blue  (m_tdata[23:16])
    );

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output stage is empty");

    a_ready_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> (s_tready && f_ready && d_ready))
        else $error("pipeline stalled although the output is taken");

    a_div_fed: assert property (@(posedge aclk) disable iff (!aresetn)
        (f_valid && !f_ready) |=> f_valid)
        else $error("front word lost while the divider stalled");

endmodule
`default_nettype wire

// File: test/hue_transfer_checker.sv
// Checker for the gray-to-color hue transfer block: watches both stream channels and the
// register port, predicts each colorized word and compares it. Depends on gthue_pkg only.
`default_nettype none
module hue_transfer_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    output int               fail_count,
    output int               pending_count,
    output int               checked_count
);
    import gthue_pkg::*;

    logic [7:0] full_scale;
    logic [7:0] gray_scale;
    logic [23:0] colors_due[$];

    function automatic logic [7:0] shade(int unsigned ch, int unsigned lt, int unsigned cr,
                                         int unsigned scale);
        int v;
        v = int'(2 * ch + 2 * lt) - int'(cr);
        if (v < 0) v = 0;
        if (v > 131072) v = 131072;
        return 8'((scale * v) >> 17);
    endfunction

    function automatic logic [23:0] colorize(logic [31:0] word, logic [7:0] fs, logic [7:0] gs);
        int unsigned mv, r, g, b, gray, hi, lo, d, cr, h, lt, hm, t, x, pr, pg, pb;
        mv = (fs == 0) ? 1 : fs;
        r = (word[7:0] > mv) ? mv : word[7:0];
        g = (word[15:8] > mv) ? mv : word[15:8];
        b = (word[23:16] > mv) ? mv : word[23:16];
        gray = word[31:24];
        if (gs == 0) return 24'd0;
        hi = (r > g) ? r : g;
        if (b > hi) hi = b;
        lo = (r < g) ? r : g;
        if (b < lo) lo = b;
        d = hi - lo;
        cr = (d * 65536) / mv;
        if (d == 0) h = 0;
        else if (hi == r) h = ((g >= b) ? 24576 + ((g - b) * 4096) / d
                                        : 24576 - ((b - g) * 4096) / d) % 24576;
        else if (hi == g) h = (b >= r) ? 8192 + ((b - r) * 4096) / d
                                       : 8192 - ((r - b) * 4096) / d;
        else h = (r >= g) ? 16384 + ((r - g) * 4096) / d : 16384 - ((g - r) * 4096) / d;
        lt = (gray * 65536 + gs - 1) / gs;
        if (lt > 131071) lt = 131071;
        hm = h % 8192;
        t = (hm >= 4096) ? hm - 4096 : 4096 - hm;
        x = (cr * (4096 - t)) >> 12;
        if (h <= 4096) begin pr = cr; pg = x; pb = 0; end
        else if (h <= 8192) begin pr = x; pg = cr; pb = 0; end
        else if (h <= 12288) begin pr = 0; pg = cr; pb = x; end
        else if (h <= 16384) begin pr = 0; pg = x; pb = cr; end
        else if (h <= 20480) begin pr = x; pg = 0; pb = cr; end
        else begin pr = cr; pg = 0; pb = x; end
        return {shade(pb, lt, cr, gs), shade(pg, lt, cr, gs), shade(pr, lt, cr, gs)};
    endfunction

    assign pending_count = colors_due.size();

    always @(posedge aclk) begin
        logic [23:0] want;
        if (!aresetn) begin
            full_scale <= 8'd255;
            gray_scale <= 8'd255;
            fail_count <= 0;
            checked_count <= 0;
            colors_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                colors_due.push_back(colorize(s_tdata, full_scale, gray_scale));
            if (m_tvalid && m_tready) begin
                checked_count <= checked_count + 1;
                if (colors_due.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = colors_due.pop_front();
                    if (want !== m_tdata) begin
                        $display("%0t: mismatch expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                                 $time, want[7:0], want[15:8], want[23:16],
                                 m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == CFG_MAX_VALUE) full_scale <= cfg_wdata;
                else gray_scale <= cfg_wdata;
            end
        end
    end
endmodule
`default_nettype wire

// File: test/tb.sv
// Top of the hue transfer testbench: clock, reset, register phases and stimulus.
// Depends on gthue_pkg, gray_to_color_hue_transfer and hue_transfer_checker.
`default_nettype none
module tb;
    import gthue_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [7:0]  cfg_wdata;
    int          fail_count;
    int          pending_count;
    int          checked_count;
    int          quiet_cycles;
    int          sent_count;
    logic        stream_done;

    gray_to_color_hue_transfer DUT (.*);
    hue_transfer_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 2000 && !(stream_done && pending_count == 0)) begin
            $display("watchdog expired");
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        int stall_left;
        m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 1) == 0) stall_left = gap_length();
            end
        end
    end

    task automatic send_pixel(logic [31:0] word);
        int idle;
        idle = gap_length();
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    task automatic write_register(logic index, logic [7:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        logic [7:0] scales[6];
        logic [7:0] grays[6];
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MAX_VALUE;
        cfg_wdata = '0;
        stream_done = 1'b0;
        sent_count = 0;
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: neutral, primaries, ties between channels, extremes of gray.
        send_pixel({8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel({8'd128, 8'd90, 8'd90, 8'd90});
        send_pixel({8'd200, 8'd0, 8'd0, 8'd255});
        send_pixel({8'd200, 8'd0, 8'd255, 8'd0});
        send_pixel({8'd200, 8'd255, 8'd0, 8'd0});
        send_pixel({8'd100, 8'd0, 8'd255, 8'd255});
        send_pixel({8'd100, 8'd255, 8'd255, 8'd0});
        send_pixel({8'd100, 8'd255, 8'd0, 8'd255});
        send_pixel({8'd60, 8'd200, 8'd10, 8'd255});
        send_pixel({8'd60, 8'd200, 8'd255, 8'd10});
        send_pixel({8'd60, 8'd10, 8'd200, 8'd255});
        send_pixel({8'd170, 8'd85, 8'd85, 8'd170});
        write_register(CFG_MAX_VALUE, 8'd100);
        write_register(CFG_MAX_GRAY, 8'd100);
        send_pixel({8'd250, 8'd200, 8'd50, 8'd150});
        send_pixel({8'd50, 8'd10, 8'd120, 8'd220});
        write_register(CFG_MAX_VALUE, 8'd0);
        write_register(CFG_MAX_GRAY, 8'd0);
        send_pixel({8'd77, 8'd1, 8'd0, 8'd200});
        send_pixel({8'd255, 8'd0, 8'd255, 8'd0});

        scales = '{8'd255, 8'd1, 8'd0, 8'd37, 8'd128, 8'd200};
        grays  = '{8'd255, 8'd1, 8'd173, 8'd0, 8'd64, 8'd255};
        for (int phase = 0; phase < 6; phase++) begin
            write_register(CFG_MAX_VALUE, scales[phase]);
            write_register(CFG_MAX_GRAY, grays[phase]);
            for (int n = 0; n < 172; n++)
                send_pixel({pick_level(), pick_level(), pick_level(), pick_level()});
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        stream_done = 1'b1;
        $display("sent %0d pixels across several register settings, %0d words checked",
                 sent_count, checked_count);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
hw/rtl/gthue_pkg.sv
hw/rtl/gthue_front.sv
hw/rtl/gthue_div.sv
hw/rtl/gthue_back.sv
hw/rtl/gray_to_color_hue_transfer.sv
test/hue_transfer_checker.sv
test/tb.sv
